// ----- src/kpb_pkg.sv -----
// ----------------------------------------------------------------------------
// kpb_pkg
// shared types, codes and constants of the keypad to pointer bridge
// ----------------------------------------------------------------------------
`default_nettype none

package kpb_pkg;

	// field widths fixed by the item format
	localparam int CODE_W   = 10;
	localparam int VALUE_W  = 12;
	localparam int POS_W    = 11;
	localparam int MOTION_W = 5;
	localparam int MS_W     = 10;
	localparam int SIZE_W   = 12;
	localparam int MU_W     = 4;

	// codes above this are dropped
	localparam logic [CODE_W-1:0] KEY_CODE_MAX = 10'd767;

	// key codes
	localparam logic [CODE_W-1:0] CODE_CENTER     = 10'd28;
	localparam logic [CODE_W-1:0] CODE_LEFT       = 10'd105;
	localparam logic [CODE_W-1:0] CODE_RIGHT      = 10'd106;
	localparam logic [CODE_W-1:0] CODE_UP         = 10'd103;
	localparam logic [CODE_W-1:0] CODE_DOWN       = 10'd108;
	localparam logic [CODE_W-1:0] CODE_LEFT_UP    = 10'd744;
	localparam logic [CODE_W-1:0] CODE_LEFT_DOWN  = 10'd745;
	localparam logic [CODE_W-1:0] CODE_RIGHT_UP   = 10'd742;
	localparam logic [CODE_W-1:0] CODE_RIGHT_DOWN = 10'd743;

	// held direction bit positions
	localparam logic [2:0] DIR_LEFT       = 3'd0;
	localparam logic [2:0] DIR_RIGHT      = 3'd1;
	localparam logic [2:0] DIR_UP         = 3'd2;
	localparam logic [2:0] DIR_DOWN       = 3'd3;
	localparam logic [2:0] DIR_LEFT_UP    = 3'd4;
	localparam logic [2:0] DIR_LEFT_DOWN  = 3'd5;
	localparam logic [2:0] DIR_RIGHT_UP   = 3'd6;
	localparam logic [2:0] DIR_RIGHT_DOWN = 3'd7;

	// result kinds
	localparam logic [2:0] KIND_KEY     = 3'd0;
	localparam logic [2:0] KIND_RELX    = 3'd1;
	localparam logic [2:0] KIND_RELY    = 3'd2;
	localparam logic [2:0] KIND_ABSX    = 3'd3;
	localparam logic [2:0] KIND_ABSY    = 3'd4;
	localparam logic [2:0] KIND_CONTACT = 3'd5;
	localparam logic [2:0] KIND_SYNC    = 3'd6;

	// input item kinds
	localparam logic ITEM_KEY  = 1'b0;
	localparam logic ITEM_TICK = 1'b1;

	// register indexes
	localparam logic [2:0] REG_MOVE_UNITS     = 3'd0;
	localparam logic [2:0] REG_DISPLAY_WIDTH  = 3'd1;
	localparam logic [2:0] REG_DISPLAY_HEIGHT = 3'd2;
	localparam logic [2:0] REG_INITIAL_REPEAT = 3'd3;
	localparam logic [2:0] REG_REPEAT         = 3'd4;

	// reset values
	localparam logic [MU_W-1:0]   MOVE_UNITS_RST     = 4'd4;
	localparam logic [SIZE_W-1:0] DISPLAY_WIDTH_RST  = 12'd480;
	localparam logic [SIZE_W-1:0] DISPLAY_HEIGHT_RST = 12'd854;
	localparam logic [MS_W-1:0]   INITIAL_REPEAT_RST = 10'd50;
	localparam logic [MS_W-1:0]   REPEAT_RST         = 10'd20;
	localparam logic [POS_W-1:0]  CURSOR_X_RST       = 11'd240;
	localparam logic [POS_W-1:0]  CURSOR_Y_RST       = 11'd427;

	// back end sequencing
	localparam int MAX_RESULTS = 5;
	localparam int STEP_W      = 3;

	// queue between front and back
	localparam int QUEUE_DEPTH_DEF = 4;

	typedef struct packed {
		logic [MU_W-1:0]   step_units;
		logic [SIZE_W-1:0] scr_width;
		logic [SIZE_W-1:0] scr_height;
		logic [MS_W-1:0]   first_delay;
		logic [MS_W-1:0]   repeat_period;
	} cfg_t;

	typedef enum logic [1:0] {
		JOB_MOTION,
		JOB_TOUCH_DOWN,
		JOB_TOUCH_UP,
		JOB_KEY
	} job_kind_t;

	typedef struct packed {
		job_kind_t                   kind;
		logic signed [MOTION_W-1:0]  dx;
		logic signed [MOTION_W-1:0]  dy;
		logic [POS_W-1:0]            abs_x;
		logic [POS_W-1:0]            abs_y;
		logic [CODE_W-1:0]           code;
		logic [1:0]                  val;
	} job_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

endpackage

`default_nettype wire

// ----- src/kpb_front.sv -----
// ----------------------------------------------------------------------------
// kpb_front
// classifies items, keeps pointer state and issues jobs to the queue
// ----------------------------------------------------------------------------
`default_nettype none

module kpb_front import kpb_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire cfg_t              cfg,
	input  wire logic              accept,
	input  wire logic              kind,
	input  wire logic [CODE_W-1:0] key_code,
	input  wire logic [1:0]        key_value,
	output logic                   push,
	output job_t                   job
);

	logic [7:0]       held_q;
	logic             center_q;
	logic [POS_W-1:0] cur_x_q;
	logic [POS_W-1:0] cur_y_q;
	logic [MS_W-1:0]  cnt_q;
	logic             armed_q;

	logic [7:0]       held_n;
	logic             center_n;
	logic [POS_W-1:0] cur_x_n;
	logic [POS_W-1:0] cur_y_n;
	logic [MS_W-1:0]  cnt_n;
	logic             armed_n;

	logic                       down;
	logic                       code_ok;
	logic                       dir_hit;
	logic [2:0]                 dir_idx;
	logic [1:0]                 x_pos, x_neg, y_pos, y_neg;
	logic signed [1:0]          sx, sy;
	logic signed [MOTION_W-1:0] dx, dy;
	logic [6:0]                 five_mu;
	logic [5:0]                 step_mag;
	logic signed [POS_W+1:0]    new_x, new_y;
	logic [POS_W-1:0]           lim_x, lim_y;
	logic [POS_W-1:0]           clamp_x, clamp_y;
	logic [MS_W-1:0]            cnt_dec;
	logic                       motion_nz;
	logic                       do_motion;

	function automatic logic [POS_W-1:0] limit_of(input logic [SIZE_W-1:0] size);
		logic [SIZE_W-1:0] m1;
		m1 = size - 12'd1;
		if (size == '0)
			return '0;
		else if (size > 12'd2048)
			return {POS_W{1'b1}};
		else
			return m1[POS_W-1:0];
	endfunction

	function automatic logic [POS_W-1:0] clamp_to(input logic signed [POS_W+1:0] v,
			input logic [POS_W-1:0] hi);
		if (v < 0)
			return '0;
		else if (v > $signed({2'b00, hi}))
			return hi;
		else
			return v[POS_W-1:0];
	endfunction

	always_comb begin
		down    = key_value != 2'd0;
		code_ok = key_code <= KEY_CODE_MAX;

		dir_hit = 1'b1;
		unique case (key_code)
			CODE_LEFT:       dir_idx = DIR_LEFT;
			CODE_RIGHT:      dir_idx = DIR_RIGHT;
			CODE_UP:         dir_idx = DIR_UP;
			CODE_DOWN:       dir_idx = DIR_DOWN;
			CODE_LEFT_UP:    dir_idx = DIR_LEFT_UP;
			CODE_LEFT_DOWN:  dir_idx = DIR_LEFT_DOWN;
			CODE_RIGHT_UP:   dir_idx = DIR_RIGHT_UP;
			CODE_RIGHT_DOWN: dir_idx = DIR_RIGHT_DOWN;
			default: begin
				dir_hit = 1'b0;
				dir_idx = DIR_LEFT;
			end
		endcase

		held_n = held_q;
		if (kind == ITEM_KEY && code_ok && dir_hit)
			held_n[dir_idx] = down;

		// net held direction per axis, as a sign
		x_pos = 2'(held_n[DIR_RIGHT]) + 2'(held_n[DIR_RIGHT_UP]) + 2'(held_n[DIR_RIGHT_DOWN]);
		x_neg = 2'(held_n[DIR_LEFT]) + 2'(held_n[DIR_LEFT_UP]) + 2'(held_n[DIR_LEFT_DOWN]);
		y_pos = 2'(held_n[DIR_DOWN]) + 2'(held_n[DIR_LEFT_DOWN]) + 2'(held_n[DIR_RIGHT_DOWN]);
		y_neg = 2'(held_n[DIR_UP]) + 2'(held_n[DIR_LEFT_UP]) + 2'(held_n[DIR_RIGHT_UP]);
		sx = (x_pos > x_neg) ? 2'sd1 : ((x_pos < x_neg) ? -2'sd1 : 2'sd0);
		sy = (y_pos > y_neg) ? 2'sd1 : ((y_pos < y_neg) ? -2'sd1 : 2'sd0);

		dx = (sx > 0) ? $signed({1'b0, cfg.step_units})
			: ((sx < 0) ? -$signed({1'b0, cfg.step_units}) : '0);
		dy = (sy > 0) ? $signed({1'b0, cfg.step_units})
			: ((sy < 0) ? -$signed({1'b0, cfg.step_units}) : '0);
		motion_nz = (dx != '0) || (dy != '0);

		// cursor step is five halves of the motion, truncated toward zero
		five_mu  = {1'b0, cfg.step_units, 2'b00} + {3'b000, cfg.step_units};
		step_mag = five_mu[6:1];
		new_x = $signed({2'b00, cur_x_q});
		new_y = $signed({2'b00, cur_y_q});
		if (sx > 0)
			new_x = new_x + $signed({7'd0, step_mag});
		else if (sx < 0)
			new_x = new_x - $signed({7'd0, step_mag});
		if (sy > 0)
			new_y = new_y + $signed({7'd0, step_mag});
		else if (sy < 0)
			new_y = new_y - $signed({7'd0, step_mag});
		lim_x   = limit_of(cfg.scr_width);
		lim_y   = limit_of(cfg.scr_height);
		clamp_x = clamp_to(new_x, lim_x);
		clamp_y = clamp_to(new_y, lim_y);

		cnt_dec = (cnt_q != '0) ? cnt_q - 10'd1 : '0;

		center_n  = center_q;
		cnt_n     = cnt_q;
		armed_n   = armed_q;
		do_motion = 1'b0;

		push      = 1'b0;
		job.kind  = JOB_MOTION;
		job.dx    = dx;
		job.dy    = dy;
		job.abs_x = cur_x_q;
		job.abs_y = cur_y_q;
		job.code  = key_code;
		job.val   = key_value;

		if (kind == ITEM_TICK) begin
			if (armed_q) begin
				cnt_n = cnt_dec;
				if (cnt_dec == '0 && motion_nz) begin
					do_motion = 1'b1;
					cnt_n     = cfg.repeat_period;
				end
			end
		end else if (code_ok) begin
			if (dir_hit) begin
				if (down && !held_q[dir_idx]) begin
					do_motion = motion_nz;
					armed_n   = 1'b1;
					cnt_n     = cfg.first_delay;
				end else if (sx == 0 && sy == 0) begin
					armed_n = 1'b0;
					cnt_n   = '0;
				end
			end else if (key_code == CODE_CENTER) begin
				if (down && !center_q) begin
					push     = 1'b1;
					job.kind = JOB_TOUCH_DOWN;
				end else if (!down && center_q) begin
					push     = 1'b1;
					job.kind = JOB_TOUCH_UP;
				end
				center_n = down;
			end else begin
				push     = 1'b1;
				job.kind = JOB_KEY;
			end
		end

		cur_x_n = cur_x_q;
		cur_y_n = cur_y_q;
		if (do_motion) begin
			push    = 1'b1;
			cur_x_n = clamp_x;
			cur_y_n = clamp_y;
		end

		push = push && accept;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q   <= '0;
			center_q <= 1'b0;
			cur_x_q  <= CURSOR_X_RST;
			cur_y_q  <= CURSOR_Y_RST;
			cnt_q    <= '0;
			armed_q  <= 1'b0;
		end else if (accept) begin
			held_q   <= held_n;
			center_q <= center_n;
			cur_x_q  <= cur_x_n;
			cur_y_q  <= cur_y_n;
			cnt_q    <= cnt_n;
			armed_q  <= armed_n;
		end
	end

endmodule

`default_nettype wire

// ----- src/kpb_queue.sv -----
// ----------------------------------------------------------------------------
// kpb_queue
// short job queue between the front and back ends
// ----------------------------------------------------------------------------
`default_nettype none

module kpb_queue import kpb_pkg::*; #(
	parameter int DEPTH = QUEUE_DEPTH_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  wire job_t wr_job,
	input  wire logic pop,
	output job_t      rd_job,
	output q_status_t status
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

	job_t             mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign rd_job       = mem_q[rd_ptr_q];
	assign status.full  = count_q == FULL_CNT;
	assign status.empty = count_q == '0;

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= wr_job;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

endmodule

`default_nettype wire

// ----- src/kpb_back.sv -----
// ----------------------------------------------------------------------------
// kpb_back
// expands each job into its result events, one per cycle while result_stall is low
// ----------------------------------------------------------------------------
`default_nettype none

module kpb_back import kpb_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire job_t               job,
	input  wire q_status_t          q_status,
	output logic                    pop,
	output logic                    result_valid,
	input  wire logic               result_stall,
	output logic [2:0]              out_kind,
	output logic [CODE_W-1:0]       out_code,
	output logic signed [VALUE_W-1:0] out_value,
	output logic                    last
);

	logic [STEP_W-1:0]         step_q;
	logic                      valid_q;
	logic [2:0]                kind_q;
	logic [CODE_W-1:0]         code_q;
	logic signed [VALUE_W-1:0] value_q;
	logic                      last_q;

	logic [2:0]                k_arr [MAX_RESULTS];
	logic signed [VALUE_W-1:0] v_arr [MAX_RESULTS];
	logic [STEP_W-1:0]         n_res;
	logic                      load;
	logic                      is_last;
	logic signed [VALUE_W-1:0] dx_ext, dy_ext, ax_ext, ay_ext;

	always_comb begin
		dx_ext = VALUE_W'(job.dx);
		dy_ext = VALUE_W'(job.dy);
		ax_ext = $signed({1'b0, job.abs_x});
		ay_ext = $signed({1'b0, job.abs_y});
		for (int i = 0; i < MAX_RESULTS; i++) begin
			k_arr[i] = KIND_SYNC;
			v_arr[i] = '0;
		end
		unique case (job.kind)
			JOB_MOTION: begin
				if (job.dx != '0 && job.dy != '0) begin
					k_arr[0] = KIND_RELX;
					v_arr[0] = dx_ext;
					k_arr[1] = KIND_RELY;
					v_arr[1] = dy_ext;
					n_res    = 3'd3;
				end else if (job.dx != '0) begin
					k_arr[0] = KIND_RELX;
					v_arr[0] = dx_ext;
					n_res    = 3'd2;
				end else begin
					k_arr[0] = KIND_RELY;
					v_arr[0] = dy_ext;
					n_res    = 3'd2;
				end
			end
			JOB_TOUCH_DOWN: begin
				k_arr[0] = KIND_ABSX;
				v_arr[0] = ax_ext;
				k_arr[1] = KIND_ABSY;
				v_arr[1] = ay_ext;
				k_arr[2] = KIND_CONTACT;
				v_arr[2] = 12'sd1;
				n_res    = 3'd4;
			end
			JOB_TOUCH_UP: begin
				k_arr[0] = KIND_ABSX;
				v_arr[0] = ax_ext;
				k_arr[1] = KIND_ABSY;
				v_arr[1] = ay_ext;
				k_arr[3] = KIND_CONTACT;
				n_res    = 3'd5;
			end
			JOB_KEY: begin
				k_arr[0] = KIND_KEY;
				v_arr[0] = $signed({10'd0, job.val});
				n_res    = 3'd2;
			end
			default: n_res = 3'd1;
		endcase

		load    = !q_status.empty && (!valid_q || !result_stall);
		is_last = step_q == n_res - 3'd1;
		pop     = load && is_last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			step_q  <= '0;
		end else begin
			if (load) begin
				valid_q <= 1'b1;
				step_q  <= is_last ? '0 : step_q + 3'd1;
			end else if (!result_stall) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			kind_q  <= k_arr[step_q];
			value_q <= v_arr[step_q];
			code_q  <= (job.kind == JOB_KEY && step_q == '0) ? job.code : '0;
			last_q  <= is_last;
		end
	end

	assign result_valid = valid_q;
	assign out_kind     = kind_q;
	assign out_code     = code_q;
	assign out_value    = value_q;
	assign last         = last_q;

endmodule

`default_nettype wire

// ----- src/keypad_to_pointer_bridge_core.sv -----
// ----------------------------------------------------------------------------
// keypad_to_pointer_bridge_core
// keypad events and millisecond ticks in, pointer and key events out
// ----------------------------------------------------------------------------
// the front end takes one request per cycle while the job queue has room,
// updates the held directions, centre flag, cursor and repeat countdown in
// that same cycle and queues at most one job per request. the back end
// expands a job into its result events at one per cycle through an output
// register while result_stall is low. a request yields no results for silent
// keys and ticks, two for a passed-through key, up to three for motion,
// four for a touch down and five for a touch up. the first result of a
// request passes through the queue and then the output register.
// item_stall rises only when the queue (QUEUE_DEPTH jobs) is full;
// result_stall holds the output register and lets the queue fill behind it.
// ----------------------------------------------------------------------------
`default_nettype none

module keypad_to_pointer_bridge_core import kpb_pkg::*; #(
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	// register port
	input  wire logic                  psel,
	input  wire logic                  penable,
	input  wire logic                  pwrite,
	input  wire logic [4:0]            paddr,
	input  wire logic [31:0]           pwdata,
	output logic [31:0]                prdata,
	output logic                       pready,
	// request channel
	input  wire logic                  item_valid,
	output logic                       item_stall,
	input  wire logic                  kind,
	input  wire logic [CODE_W-1:0]     key_code,
	input  wire logic [1:0]            key_value,
	// result channel
	output logic                       result_valid,
	input  wire logic                  result_stall,
	output logic [2:0]                 out_kind,
	output logic [CODE_W-1:0]          out_code,
	output logic signed [VALUE_W-1:0]  out_value,
	output logic                       last
);

	cfg_t       cfg_q;
	logic       reg_wr;
	logic [2:0] reg_idx;
	logic       accept;
	logic       push;
	logic       pop;
	job_t       wr_job;
	job_t       rd_job;
	q_status_t  q_status;

	// register access, always ready
	assign pready  = 1'b1;
	assign reg_idx = paddr[4:2];
	assign reg_wr  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.step_units    <= MOVE_UNITS_RST;
			cfg_q.scr_width     <= DISPLAY_WIDTH_RST;
			cfg_q.scr_height    <= DISPLAY_HEIGHT_RST;
			cfg_q.first_delay   <= INITIAL_REPEAT_RST;
			cfg_q.repeat_period <= REPEAT_RST;
		end else if (reg_wr) begin
			unique case (reg_idx)
				REG_MOVE_UNITS:     cfg_q.step_units    <= pwdata[MU_W-1:0];
				REG_DISPLAY_WIDTH:  cfg_q.scr_width     <= pwdata[SIZE_W-1:0];
				REG_DISPLAY_HEIGHT: cfg_q.scr_height    <= pwdata[SIZE_W-1:0];
				REG_INITIAL_REPEAT: cfg_q.first_delay   <= pwdata[MS_W-1:0];
				REG_REPEAT:         cfg_q.repeat_period <= pwdata[MS_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_MOVE_UNITS:     prdata = {28'd0, cfg_q.step_units};
			REG_DISPLAY_WIDTH:  prdata = {20'd0, cfg_q.scr_width};
			REG_DISPLAY_HEIGHT: prdata = {20'd0, cfg_q.scr_height};
			REG_INITIAL_REPEAT: prdata = {22'd0, cfg_q.first_delay};
			REG_REPEAT:         prdata = {22'd0, cfg_q.repeat_period};
			default:            prdata = '0;
		endcase
	end

	// front end: stalls only on a full queue
	assign item_stall = q_status.full;
	assign accept     = item_valid && !item_stall;

	kpb_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.accept    (accept),
		.kind      (kind),
		.key_code  (key_code),
		.key_value (key_value),
		.push      (push),
		.job       (wr_job)
	);

	kpb_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wr_job (wr_job),
		.pop    (pop),
		.rd_job (rd_job),
		.status (q_status)
	);

	// back end: one result per cycle into the output register while result_stall is low
	kpb_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.job          (rd_job),
		.q_status     (q_status),
		.pop          (pop),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.out_kind     (out_kind),
		.out_code     (out_code),
		.out_value    (out_value),
		.last         (last)
	);

endmodule

`default_nettype wire
